// File: rtl/idxp_pkg.sv
// Shared types, codes and decode helpers for the IDX header stream parser.
package idxp_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_DIMS  = 3'd1,
    PH_DATA  = 3'd2,
    PH_DONE  = 3'd3,
    PH_ERROR = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_MAGIC   = 3'd1,
    ERR_BAD_MAGIC  = 3'd2,
    ERR_BAD_TYPE   = 3'd3,
    ERR_SHORT_DIMS = 3'd4,
    ERR_BAD_LENGTH = 3'd5,
    ERR_SHORT_DATA = 3'd6
  } err_e;

  localparam logic [7:0] TYPE_U8  = 8'h08;
  localparam logic [7:0] TYPE_S8  = 8'h09;
  localparam logic [7:0] TYPE_S16 = 8'h0B;
  localparam logic [7:0] TYPE_S32 = 8'h0C;
  localparam logic [7:0] TYPE_F32 = 8'h0D;
  localparam logic [7:0] TYPE_F64 = 8'h0E;

  localparam int unsigned COUNT_W = 64;
  localparam int unsigned HDR_W   = 11;

  // Result flags of the header length check.
  typedef struct packed {
    logic fits;       // length minus header is non-negative and a whole number of elements
    logic data_zero;  // no payload follows the header
  } len_chk_t;

  // Element size in bytes for a type code; zero for an unknown code.
  function automatic logic [3:0] decode_size(input logic [7:0] code);
    logic [3:0] sz;
    unique case (code) inside
      TYPE_U8, TYPE_S8:   sz = 4'd1;
      TYPE_S16:           sz = 4'd2;
      TYPE_S32, TYPE_F32: sz = 4'd4;
      TYPE_F64:           sz = 4'd8;
      default:            sz = 4'd0;
    endcase
    return sz;
  endfunction

  // log2 of an element size.
  function automatic logic [1:0] size_shift(input logic [3:0] sz);
    logic [1:0] k;
    unique case (sz)
      4'd2:    k = 2'd1;
      4'd4:    k = 2'd2;
      4'd8:    k = 2'd3;
      default: k = 2'd0;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/idxp_len_check.sv
// Header length check: payload length and expected element count from the file length.
module idxp_len_check #(
  parameter int unsigned LW = 48
) (
  input  logic [LW-1:0]           file_length_i,
  input  logic [7:0]              dims_i,
  input  logic [3:0]              elem_size_i,
  output logic [LW-1:0]           data_len_o,
  output logic [LW-1:0]           target_count_o,
  output idxp_pkg::len_chk_t      chk_o
);
  import idxp_pkg::*;

  logic [HDR_W-1:0] hdr_len;
  logic [LW:0]      diff;
  logic [1:0]       k;
  logic [2:0]       low_bits;

  // header is 4 bytes plus 4 per dimension
  assign hdr_len  = {1'b0, dims_i, 2'b00} + HDR_W'(4);
  assign diff     = {1'b0, file_length_i} - {{(LW + 1 - HDR_W){1'b0}}, hdr_len};
  assign k        = size_shift(elem_size_i);
  assign low_bits = diff[2:0] & ~(3'b111 << k);

  assign data_len_o     = diff[LW-1:0];
  assign target_count_o = diff[LW-1:0] >> k;
  assign chk_o.fits      = !diff[LW] && (low_bits == 3'd0);
  assign chk_o.data_zero = (diff[LW-1:0] == '0);

endmodule

// File: rtl/idxp_count.sv
// Element count: byte-serial multiply of the running count by each dimension size.
module idxp_count (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          last_i,
  input  logic [7:0]                    byte_i,
  input  logic                          size_zero_i,
  output logic [idxp_pkg::COUNT_W-1:0]  count_next_o,
  output logic                          ovf_next_o
);
  import idxp_pkg::*;

  localparam int unsigned ACC_W = COUNT_W + 32;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [COUNT_W-1:0] count_q;
  logic               ovf_q;
  logic [COUNT_W+7:0] part;
  logic [ACC_W-1:0]   prod;

  // Horner step: acc = acc * 256 + count * byte
  assign part = count_q * byte_i;
  assign prod = {acc_q[ACC_W-9:0], 8'h00} + {{(ACC_W - COUNT_W - 8){1'b0}}, part};

  always_comb begin
    acc_d        = acc_q;
    count_next_o = count_q;
    ovf_next_o   = ovf_q;
    if (en_i) begin
      acc_d = last_i ? '0 : prod;
      if (last_i) begin
        if (size_zero_i) begin
          count_next_o = '0;
          ovf_next_o   = 1'b0;
        end else if (!ovf_q) begin
          if (prod[ACC_W-1:COUNT_W] != '0) begin
            // saturate
            count_next_o = '1;
            ovf_next_o   = 1'b1;
          end else begin
            count_next_o = prod[COUNT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      count_q <= COUNT_W'(1);
      ovf_q   <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      count_q <= count_next_o;
      ovf_q   <= ovf_next_o;
    end
  end

endmodule

// File: rtl/idx_header_stream_parser.sv
// Top level: input register, header/payload parse state machine and result register.
// A byte passes the input register, then the result register, to the master side.
// Throughput: one byte per cycle unless the master side stalls; the parse update and
// the count multiply step both complete between the input register and result register.
// Reset: asynchronous, active low; returns to the magic phase with count 1, no error,
// file_length 0. After an error or the end of data, bytes are consumed until reset.
module idx_header_stream_parser #(
  parameter int unsigned LENGTH_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,       // file_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,      // [7:0] in_byte
  input  logic        s_axis_tlast,      // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [11:8] element_bytes, [19:12] dim_count,
  // [83:20] element_count, [86:84] error_code, [87] zero
  output logic [87:0] m_axis_tdata,
  // [0] payload_valid, [1] element_end, [2] header_ok
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast       // stream_end
);
  import idxp_pkg::*;

  localparam int unsigned LW = (LENGTH_BITS < 48) ? LENGTH_BITS : 48;

  // configuration
  logic [LW-1:0] file_length_q;

  // input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_eof_q;

  // parse state
  phase_e        phase_q, phase_d;
  err_e          err_q, err_d;
  logic [1:0]    bif_q, bif_d;
  logic [3:0]    elem_size_q, elem_size_d;
  logic [7:0]    dims_total_q, dims_total_d;
  logic [7:0]    dims_seen_q, dims_seen_d;
  logic [23:0]   sacc_q, sacc_d;
  logic [LW-1:0] bytes_left_q, bytes_left_d;
  logic [2:0]    bie_q, bie_d;

  // result register
  logic                out_v_q;
  logic [7:0]          out_byte_q;
  logic [3:0]          out_esize_q;
  logic [7:0]          out_dims_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [2:0]          out_err_q;
  logic                out_pv_q, out_ee_q, out_se_q, out_hok_q;

  logic adv, step;
  logic pv, ee, se, hok;

  logic       last_bif;
  logic       magic_bad;
  logic [3:0] dec_size;
  logic       dims_done;
  logic [7:0] dims_seen_inc;
  logic       size_zero;
  logic       fin_pass;
  logic [3:0] bie_inc;
  logic [LW-1:0] bytes_left_dec;

  logic [7:0]          lc_dims;
  logic [3:0]          lc_esize;
  logic [LW-1:0]       data_len;
  logic [LW-1:0]       target_count;
  len_chk_t            lc;
  logic [COUNT_W-1:0]  count_next;
  logic                ovf_next;

  assign adv           = !out_v_q || m_axis_tready;
  assign step          = in_v_q && adv;
  assign s_axis_tready = !in_v_q || adv;

  assign last_bif      = (bif_q == 2'd3);
  assign magic_bad     = (sacc_q[23:16] != 8'h00) || (sacc_q[15:8] != 8'h00);
  assign dec_size      = decode_size(sacc_q[7:0]);
  assign dims_seen_inc = dims_seen_q + 8'd1;
  assign dims_done     = (dims_seen_inc == dims_total_q);
  assign size_zero     = ({sacc_q, in_byte_q} == 32'd0);
  assign bie_inc       = {1'b0, bie_q} + 4'd1;
  assign bytes_left_dec = (bytes_left_q != '0) ? bytes_left_q - LW'(1) : bytes_left_q;

  // header geometry seen by the length check: zero dims when finishing on the dimension count byte
  assign lc_dims  = (phase_q == PH_MAGIC) ? 8'd0 : dims_total_q;
  assign lc_esize = (phase_q == PH_MAGIC) ? dec_size : elem_size_q;

  idxp_len_check #(
    .LW (LW)
  ) u_len_check (
    .file_length_i  (file_length_q),
    .dims_i         (lc_dims),
    .elem_size_i    (lc_esize),
    .data_len_o     (data_len),
    .target_count_o (target_count),
    .chk_o          (lc)
  );

  idxp_count u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (step && (phase_q == PH_DIMS)),
    .last_i       (last_bif),
    .byte_i       (in_byte_q),
    .size_zero_i  (size_zero),
    .count_next_o (count_next),
    .ovf_next_o   (ovf_next)
  );

  assign fin_pass = lc.fits && !ovf_next &&
                    (count_next == {{(COUNT_W - LW){1'b0}}, target_count});

  // next state
  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    if (step) begin
      unique case (phase_q)
        PH_MAGIC: begin
          if (!last_bif) begin
            if (in_eof_q) begin
              phase_d = PH_ERROR;
              err_d   = ERR_NO_MAGIC;
            end
          end else if (magic_bad) begin
            phase_d = PH_ERROR;
            err_d   = ERR_BAD_MAGIC;
          end else if (dec_size == 4'd0) begin
            phase_d = PH_ERROR;
            err_d   = ERR_BAD_TYPE;
          end else if (in_byte_q == 8'd0) begin
            if (!fin_pass) begin
              phase_d = PH_ERROR;
              err_d   = ERR_BAD_LENGTH;
            end else if (lc.data_zero) begin
              phase_d = PH_DONE;
            end else if (in_eof_q) begin
              phase_d = PH_ERROR;
              err_d   = ERR_SHORT_DATA;
            end else begin
              phase_d = PH_DATA;
            end
          end else if (in_eof_q) begin
            phase_d = PH_ERROR;
            err_d   = ERR_SHORT_DIMS;
          end else begin
            phase_d = PH_DIMS;
          end
        end
        PH_DIMS: begin
          if (last_bif && dims_done) begin
            if (!fin_pass) begin
              phase_d = PH_ERROR;
              err_d   = ERR_BAD_LENGTH;
            end else if (lc.data_zero) begin
              phase_d = PH_DONE;
            end else if (in_eof_q) begin
              phase_d = PH_ERROR;
              err_d   = ERR_SHORT_DATA;
            end else begin
              phase_d = PH_DATA;
            end
          end else if (in_eof_q) begin
            phase_d = PH_ERROR;
            err_d   = ERR_SHORT_DIMS;
          end
        end
        PH_DATA: begin
          if (bytes_left_dec == '0) begin
            phase_d = PH_DONE;
          end else if (in_eof_q) begin
            phase_d = PH_ERROR;
            err_d   = ERR_SHORT_DATA;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath and result flags
  always_comb begin
    bif_d        = bif_q;
    elem_size_d  = elem_size_q;
    dims_total_d = dims_total_q;
    dims_seen_d  = dims_seen_q;
    sacc_d       = sacc_q;
    bytes_left_d = bytes_left_q;
    bie_d        = bie_q;
    pv           = 1'b0;
    ee           = 1'b0;
    se           = 1'b0;
    hok          = 1'b0;
    if (step) begin
      unique case (phase_q)
        PH_MAGIC: begin
          sacc_d = {sacc_q[15:0], in_byte_q};
          bif_d  = bif_q + 2'd1;
          if (last_bif && !magic_bad && (dec_size != 4'd0)) begin
            elem_size_d  = dec_size;
            dims_total_d = in_byte_q;
            dims_seen_d  = 8'd0;
            sacc_d       = '0;
            if ((in_byte_q == 8'd0) && fin_pass) begin
              hok          = 1'b1;
              bytes_left_d = data_len;
              bie_d        = 3'd0;
            end
          end
        end
        PH_DIMS: begin
          sacc_d = {sacc_q[15:0], in_byte_q};
          bif_d  = bif_q + 2'd1;
          if (last_bif) begin
            sacc_d      = '0;
            dims_seen_d = dims_seen_inc;
            if (dims_done && fin_pass) begin
              hok          = 1'b1;
              bytes_left_d = data_len;
              bie_d        = 3'd0;
            end
          end
        end
        PH_DATA: begin
          pv           = 1'b1;
          bytes_left_d = bytes_left_dec;
          if (bie_inc >= elem_size_q) begin
            ee    = 1'b1;
            bie_d = 3'd0;
          end else begin
            bie_d = bie_inc[2:0];
          end
          se = (bytes_left_dec == '0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
      in_v_q        <= 1'b0;
      phase_q       <= PH_MAGIC;
      err_q         <= ERR_NONE;
      bif_q         <= 2'd0;
      elem_size_q   <= 4'd0;
      dims_total_q  <= 8'd0;
      dims_seen_q   <= 8'd0;
      sacc_q        <= '0;
      bytes_left_q  <= '0;
      bie_q         <= 3'd0;
      out_v_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        file_length_q <= cfg_wdata_i[LW-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_v_q <= 1'b1;
      end else if (step) begin
        in_v_q <= 1'b0;
      end
      phase_q      <= phase_d;
      err_q        <= err_d;
      bif_q        <= bif_d;
      elem_size_q  <= elem_size_d;
      dims_total_q <= dims_total_d;
      dims_seen_q  <= dims_seen_d;
      sacc_q       <= sacc_d;
      bytes_left_q <= bytes_left_d;
      bie_q        <= bie_d;
      if (step) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers: load the request and its result
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eof_q  <= s_axis_tlast;
    end
    if (step) begin
      out_byte_q  <= pv ? in_byte_q : 8'h00;
      out_esize_q <= elem_size_d;
      out_dims_q  <= dims_total_d;
      out_count_q <= count_next;
      out_err_q   <= err_d;
      out_pv_q    <= pv;
      out_ee_q    <= ee;
      out_se_q    <= se;
      out_hok_q   <= hok;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_err_q, out_count_q, out_dims_q, out_esize_q, out_byte_q};
  assign m_axis_tuser  = {out_hok_q, out_ee_q, out_pv_q};
  assign m_axis_tlast  = out_se_q;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the IDX header stream parser: one file, header then payload.
module tb;
  import idxp_pkg::*;

  localparam int DIR_N      = 24;
  localparam int FILE_BYTES = 1212;  // 4 + 4*2 + 15*80 for every element size
  localparam int RAND_DATA  = 1188;  // payload bytes left after the directed rows
  localparam int NOISE_N    = 40;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        element_end;
    logic        stream_end;
    logic        header_ok;
    logic [3:0]  element_bytes;
    logic [7:0]  dim_count;
    logic [63:0] element_count;
    err_e        error_code;
  } parse_out_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    parse_out_t want;
  } stim_row_t;

  localparam parse_out_t AFTER_RESET = '{payload_byte: 8'h00, payload_valid: 1'b0,
    element_end: 1'b0, stream_end: 1'b0, header_ok: 1'b0, element_bytes: 4'd0,
    dim_count: 8'd0, element_count: 64'd1, error_code: ERR_NONE};
  localparam parse_out_t NO_WANT = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [47:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  idx_header_stream_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Parser state as the predictor sees it.
  phase_e      p_phase;
  logic [1:0]  p_fld;
  logic [3:0]  p_esz;
  logic [7:0]  p_ndims;
  logic [7:0]  p_dseen;
  logic [31:0] p_acc;
  logic [63:0] p_cnt;
  logic        p_ovf;
  logic [63:0] p_left;
  logic [2:0]  p_epos;
  err_e        p_err;
  logic [47:0] p_flen;

  parse_out_t  due_results[$];
  stim_row_t   dir_tab[DIR_N];
  int          mismatches;
  int          bytes_sent;
  int          send_idle_pct;
  int          recv_idle_pct;

  function automatic logic [3:0] type_bytes(input logic [7:0] code);
    case (code)
      TYPE_U8, TYPE_S8:   return 4'd1;
      TYPE_S16:           return 4'd2;
      TYPE_S32, TYPE_F32: return 4'd4;
      TYPE_F64:           return 4'd8;
      default:            return 4'd0;
    endcase
  endfunction

  task automatic latch_error(input err_e code);
    p_err   = code;
    p_phase = PH_ERROR;
  endtask

  // Length check on the byte that completes the header.
  task automatic close_header(input logic eof, inout logic hok);
    logic [127:0] data_w;
    logic [64:0]  total_w;
    data_w = p_cnt * p_esz;
    if (p_ovf || p_esz == 4'd0 || data_w[127:64] != '0) begin
      latch_error(ERR_BAD_LENGTH);
      return;
    end
    total_w = data_w[63:0] + 65'd4 + 65'd4 * p_ndims;
    if (total_w[64:48] != '0 || total_w[47:0] != p_flen) begin
      latch_error(ERR_BAD_LENGTH);
      return;
    end
    hok    = 1'b1;
    p_left = data_w[63:0];
    p_epos = 3'd0;
    if (data_w == '0) begin
      p_phase = PH_DONE;
    end else begin
      p_phase = PH_DATA;
      if (eof) latch_error(ERR_SHORT_DATA);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof, output parse_out_t r);
    logic         hok;
    logic [127:0] wide;
    r   = '0;
    hok = 1'b0;
    case (p_phase)
      PH_MAGIC: begin
        p_acc = {p_acc[23:0], b};
        if (p_fld < 2'd3) begin
          p_fld++;
          if (eof) latch_error(ERR_NO_MAGIC);
        end else begin
          p_fld = 2'd0;
          if (p_acc[31:16] != '0) begin
            latch_error(ERR_BAD_MAGIC);
          end else if (type_bytes(p_acc[15:8]) == 4'd0) begin
            latch_error(ERR_BAD_TYPE);
          end else begin
            p_esz   = type_bytes(p_acc[15:8]);
            p_ndims = b;
            p_dseen = 8'd0;
            p_acc   = '0;
            if (p_ndims == 8'd0) begin
              close_header(eof, hok);
            end else begin
              p_phase = PH_DIMS;
              if (eof) latch_error(ERR_SHORT_DIMS);
            end
          end
        end
      end
      PH_DIMS: begin
        p_acc = {p_acc[23:0], b};
        if (p_fld < 2'd3) begin
          p_fld++;
          if (eof) latch_error(ERR_SHORT_DIMS);
        end else begin
          p_fld = 2'd0;
          // a zero size clears the count and any earlier overflow
          if (p_acc == '0) begin
            p_cnt = '0;
            p_ovf = 1'b0;
          end else if (!p_ovf) begin
            wide = p_cnt * p_acc;
            if (wide[127:64] != '0) begin
              p_cnt = '1;
              p_ovf = 1'b1;
            end else begin
              p_cnt = wide[63:0];
            end
          end
          p_acc = '0;
          p_dseen++;
          if (p_dseen == p_ndims) close_header(eof, hok);
          else if (eof) latch_error(ERR_SHORT_DIMS);
        end
      end
      PH_DATA: begin
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        if (p_left != '0) p_left--;
        if (int'(p_epos) + 1 >= int'(p_esz)) begin
          r.element_end = 1'b1;
          p_epos        = 3'd0;
        end else begin
          p_epos = p_epos + 3'd1;
        end
        if (p_left == '0) begin
          r.stream_end = 1'b1;
          p_phase      = PH_DONE;
        end else if (eof) begin
          latch_error(ERR_SHORT_DATA);
        end
      end
      default: ;
    endcase
    r.header_ok     = hok;
    r.element_bytes = p_esz;
    r.dim_count     = p_ndims;
    r.element_count = p_cnt;
    r.error_code    = p_err;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Offer one request, wait for the handshake and queue its expected result.
  task automatic send_byte(input logic [7:0] b, input logic eof, input bit typed,
                           input parse_out_t typed_want);
    parse_out_t pred;
    if (bytes_sent < 420) begin
      send_idle_pct = 21;
      recv_idle_pct = 69;
    end else if (bytes_sent < 840) begin
      send_idle_pct = 69;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_byte(b, eof, pred);
    due_results.push_back(typed ? typed_want : pred);
    bytes_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_file_length(input logic [47:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    p_flen = v;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the input side backs up.
  initial begin : rx_ctl
    int seen;
    int hold_left;
    bit held;
    m_axis_tready = 1'b0;
    seen          = 0;
    hold_left     = 0;
    held          = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) seen++;
      if (!held && seen >= 950) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    parse_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
      end else begin
        want = due_results.pop_front();
        check_field("payload_byte", 64'(m_axis_tdata[7:0]), 64'(want.payload_byte));
        check_field("element_bytes", 64'(m_axis_tdata[11:8]), 64'(want.element_bytes));
        check_field("dim_count", 64'(m_axis_tdata[19:12]), 64'(want.dim_count));
        check_field("element_count", m_axis_tdata[83:20], want.element_count);
        check_field("error_code", 64'(m_axis_tdata[86:84]), 64'(want.error_code));
        check_field("tdata pad", 64'(m_axis_tdata[87]), 64'd0);
        check_field("payload_valid", 64'(m_axis_tuser[0]), 64'(want.payload_valid));
        check_field("element_end", 64'(m_axis_tuser[1]), 64'(want.element_end));
        check_field("header_ok", 64'(m_axis_tuser[2]), 64'(want.header_ok));
        check_field("stream_end", 64'(m_axis_tlast), 64'(want.stream_end));
      end
    end
  end

  initial begin
    logic [7:0] codes[6];
    logic [7:0] sel;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    mismatches    = 0;
    bytes_sent    = 0;
    send_idle_pct = 21;
    recv_idle_pct = 69;
    p_phase = PH_MAGIC;
    p_fld   = '0;
    p_esz   = '0;
    p_ndims = '0;
    p_dseen = '0;
    p_acc   = '0;
    p_cnt   = 64'd1;
    p_ovf   = 1'b0;
    p_left  = '0;
    p_epos  = '0;
    p_err   = ERR_NONE;
    p_flen  = '0;

    // Header of a two-dimensional file, 15 x (80 / element size), then payload extremes.
    dir_tab = '{
      '{8'h00, 1'b0, 1'b1, AFTER_RESET},
      '{8'h00, 1'b0, 1'b1, AFTER_RESET},
      '{TYPE_F32, 1'b0, 1'b1, AFTER_RESET},
      '{8'h02, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h0F, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h14, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'hFF, 1'b0, 1'b0, NO_WANT},
      '{8'h01, 1'b0, 1'b0, NO_WANT},
      '{8'h80, 1'b0, 1'b0, NO_WANT},
      '{8'h7F, 1'b0, 1'b0, NO_WANT},
      '{8'hFE, 1'b0, 1'b0, NO_WANT},
      '{8'h55, 1'b0, 1'b0, NO_WANT},
      '{8'hAA, 1'b0, 1'b0, NO_WANT},
      '{8'h0F, 1'b0, 1'b0, NO_WANT},
      '{8'hF0, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'hFF, 1'b0, 1'b0, NO_WANT}
    };
    // Pick the element type; resize the second dimension to keep the data at 1200 bytes.
    codes = '{TYPE_U8, TYPE_S8, TYPE_S16, TYPE_S32, TYPE_F32, TYPE_F64};
    sel   = codes[$urandom_range(0, 5)];
    dir_tab[2].data  = sel;
    dir_tab[11].data = 8'(80 / type_bytes(sel));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_file_length('1);
    for (int i = 0; i < 2; i++)
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    drain();
    write_file_length('0);
    for (int i = 2; i < 4; i++)
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    drain();
    write_file_length(48'(FILE_BYTES));
    for (int i = 4; i < DIR_N; i++)
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    drain();
    // Length is only checked at the end of the header; change it mid-payload anyway.
    write_file_length(48'({$urandom, $urandom}));

    for (int i = 0; i < RAND_DATA; i++)
      send_byte(8'($urandom_range(0, 255)), i == RAND_DATA - 1, 1'b0, NO_WANT);
    // Bytes after the end of data are consumed without effect.
    for (int i = 0; i < NOISE_N; i++)
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, NO_WANT);
    drain();
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
